// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/dcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Delayed command device package
// Word types, register indexes and constants shared by the block.
// ----------------------------------------------------------------------------
package dcd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE       = 3'd0,
    CFG_SENS_INTERVAL = 3'd1,
    CFG_SENS_AMPL    = 3'd2,
    CFG_SENS_BASE    = 3'd3,
    CFG_CMD_DELAY    = 3'd4,
    CFG_FAULT_MASK   = 3'd5,
    CFG_FAULT_PROB   = 3'd6
  } cfg_idx_e;

  // Fault mask bit positions.
  localparam int unsigned FaultError   = 0;
  localparam int unsigned FaultOnes    = 1;
  localparam int unsigned FaultTimeout = 2;
  localparam int unsigned FaultStuck   = 3;

  localparam logic [15:0] IntervalDefault = 16'd100;
  localparam logic [13:0] ProbAlways      = 14'd10000;
  localparam logic [31:0] AllOnes         = 32'hFFFF_FFFF;
  localparam logic [2:0]  PhaseLast       = 3'h7;

  localparam logic [15:0] RstInterval = 16'd100;
  localparam logic [15:0] RstAmpl     = 16'd64;
  localparam logic [31:0] RstBase     = 32'h0000_1000;
  localparam logic [31:0] RstDelay    = 32'd500;

  typedef struct packed {
    logic        enable;
    logic [15:0] sensor_interval;
    logic [15:0] sensor_amplitude;
    logic [31:0] sensor_base;
    logic [31:0] command_delay;
    logic [3:0]  fault_select;
    logic [13:0] fault_probability;
  } cfg_t;

  typedef struct packed {
    logic en_rise;
    logic en_fall;
  } cfg_evt_t;

  typedef struct packed {
    logic        action;
    logic [31:0] command_data;
    logic [13:0] random_draw;
  } in_item_t;

  typedef struct packed {
    logic        busy_res;
    logic        data_available;
    logic        error_flag;
    logic [31:0] read_data;
    logic [31:0] sensor_value;
    logic [31:0] operation_count;
    logic        rejected;
  } res_item_t;

  // Command path view after the current word.
  typedef struct packed {
    logic        busy;
    logic        dav;
    logic        err;
    logic [31:0] result;
    logic [31:0] op_count;
    logic        rejected;
  } cmd_view_t;

endpackage

// ===== rtl/core/dcd_chan_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one word of type T per handshake.
// ----------------------------------------------------------------------------
interface dcd_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/delayed_command_device_with_faults.sv =====
// ----------------------------------------------------------------------------
// Delayed command device with faults
// Test peripheral with tick-driven command completion, a sensor triangle
// wave and injectable error, all-ones, timeout and stuck-busy faults.
// ----------------------------------------------------------------------------
// Every input word (a tick or a GO) is taken in a single handshake: the command engine
// and the sensor generator update their state at the accepting edge, and the
// status seen after that word is written into a two-word result queue in the
// same edge. A word is accepted whenever the queue has a free slot, so the
// block runs at one word per clock while results are taken, and can absorb one
// more word while a result waits on a stalled output. A result is registered in
// the queue and reaches the output once the results ahead of it are taken.
module delayed_command_device_with_faults #(
  parameter int unsigned BUSY_PERIOD = 50
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dcd_pkg::CfgDataW-1:0] cfg_data_i,
  dcd_chan_if.sink                     item_i,
  dcd_chan_if.source                   result_o
);
  import dcd_pkg::*;

  cfg_t      cfg;
  cfg_evt_t  evt;
  cmd_view_t view;
  res_item_t res;
  in_item_t  item;
  logic      accept, tick, go, q_ready;
  logic [31:0] sensor_d;

  assign item   = item_i.payload;
  assign accept = item_i.valid && q_ready;
  assign tick   = accept && cfg.enable && !item.action;
  assign go     = accept && cfg.enable && item.action;

  assign item_i.ready = q_ready;

  dcd_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .evt_o      (evt)
  );

  dcd_sensor u_sensor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .cfg_i      (cfg),
    .evt_i      (evt),
    .sensor_d_o (sensor_d)
  );

  dcd_cmd #(
    .BUSY_PERIOD (BUSY_PERIOD)
  ) u_cmd (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (tick),
    .go_i           (go),
    .command_data_i (item.command_data),
    .random_draw_i  (item.random_draw),
    .cfg_i          (cfg),
    .evt_i          (evt),
    .view_o         (view)
  );

  assign res.busy_res        = view.busy;
  assign res.data_available  = view.dav;
  assign res.error_flag      = view.err;
  assign res.read_data       = view.result;
  assign res.sensor_value    = sensor_d;
  assign res.operation_count = view.op_count;
  assign res.rejected        = view.rejected;

  dcd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .in_ready_o  (q_ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (result_o.payload)
  );

endmodule

// ===== rtl/core/dcd_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the settings and flags the edges of the enable bit.
// ----------------------------------------------------------------------------
module dcd_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dcd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dcd_pkg::CfgDataW-1:0]   cfg_data_i,
  output dcd_pkg::cfg_t                  cfg_o,
  output dcd_pkg::cfg_evt_t              evt_o
);
  import dcd_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic en_wr;

  assign en_wr = cfg_we_i && (cfg_idx_i == CFG_ENABLE);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:        cfg_d.enable            = cfg_data_i[0];
        CFG_SENS_INTERVAL: cfg_d.sensor_interval   = cfg_data_i[15:0];
        CFG_SENS_AMPL:     cfg_d.sensor_amplitude  = cfg_data_i[15:0];
        CFG_SENS_BASE:     cfg_d.sensor_base       = cfg_data_i;
        CFG_CMD_DELAY:     cfg_d.command_delay     = cfg_data_i;
        CFG_FAULT_MASK:    cfg_d.fault_select      = cfg_data_i[3:0];
        CFG_FAULT_PROB:    cfg_d.fault_probability = cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable            <= 1'b0;
      cfg_q.sensor_interval   <= RstInterval;
      cfg_q.sensor_amplitude  <= RstAmpl;
      cfg_q.sensor_base       <= RstBase;
      cfg_q.command_delay     <= RstDelay;
      cfg_q.fault_select      <= '0;
      cfg_q.fault_probability <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o         = cfg_q;
  assign evt_o.en_rise = en_wr && cfg_data_i[0] && !cfg_q.enable;
  assign evt_o.en_fall = en_wr && !cfg_data_i[0] && cfg_q.enable;

endmodule

// ===== rtl/core/dcd_sensor.sv =====
// ----------------------------------------------------------------------------
// Sensor generator
// Steps an eight-phase triangle wave once per sensor interval.
// ----------------------------------------------------------------------------
module dcd_sensor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  dcd_pkg::cfg_t     cfg_i,
  input  dcd_pkg::cfg_evt_t evt_i,
  output logic [31:0]       sensor_d_o
);
  import dcd_pkg::*;

  logic [15:0] timer_q, timer_d, timer_inc, interval;
  logic [2:0]  phase_q, phase_d;
  logic [31:0] value_q, value_d;
  logic [1:0]  step;
  logic [15:0] swing;

  assign interval  = (cfg_i.sensor_interval == '0) ? IntervalDefault : cfg_i.sensor_interval;
  assign timer_inc = timer_q + 16'd1;

  // Phases 0..3 climb and 4..7 fall back toward the baseline.
  assign step  = phase_d[2] ? 2'(PhaseLast - phase_d) : phase_d[1:0];
  assign swing = 16'(step) * 16'(cfg_i.sensor_amplitude[15:2]);

  always_comb begin
    timer_d = timer_q;
    phase_d = phase_q;
    value_d = value_q;
    if (tick_i) begin
      timer_d = timer_inc;
      if (timer_inc >= interval) begin
        timer_d = '0;
        phase_d = phase_q + 3'd1;
        value_d = cfg_i.sensor_base + 32'(swing);
      end
    end
    if (evt_i.en_rise) begin
      timer_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
      phase_q <= '0;
      value_q <= '0;
    end else begin
      timer_q <= timer_d;
      phase_q <= phase_d;
      value_q <= value_d;
    end
  end

  assign sensor_d_o = value_d;

endmodule

// ===== rtl/core/dcd_cmd.sv =====
// ----------------------------------------------------------------------------
// Command engine
// GO capture, fault draw, completion countdown, status and stuck busy.
// ----------------------------------------------------------------------------
module dcd_cmd #(
  parameter int unsigned BUSY_PERIOD = 50
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_i,
  input  logic               go_i,
  input  logic [31:0]        command_data_i,
  input  logic [13:0]        random_draw_i,
  input  dcd_pkg::cfg_t      cfg_i,
  input  dcd_pkg::cfg_evt_t  evt_i,
  output dcd_pkg::cmd_view_t view_o
);
  import dcd_pkg::*;

  localparam int unsigned BtW = $clog2(BUSY_PERIOD + 1);

  logic           pending_q, pending_d;
  logic           armed_q, armed_d;
  logic [31:0]    ctimer_q, ctimer_d, ctimer_dec;
  logic [31:0]    cap_data_q, cap_data_d;
  logic [3:0]     cap_fault_q, cap_fault_d;
  logic           busy_q, busy_d, dav_q, dav_d, err_q, err_d;
  logic [31:0]    result_q, result_d;
  logic [31:0]    op_cnt_q, op_cnt_d;
  logic [BtW-1:0] btimer_q, btimer_d, btimer_inc;
  logic           prob_hit, fault;
  logic           rejected;

  assign ctimer_dec = ctimer_q - 32'd1;
  assign btimer_inc = btimer_q + BtW'(1);

  assign prob_hit = (cfg_i.fault_probability != '0) &&
                    ((cfg_i.fault_probability >= ProbAlways) ||
                     (random_draw_i < cfg_i.fault_probability));
  assign fault    = (cfg_i.fault_select != '0) && prob_hit;

  always_comb begin
    pending_d   = pending_q;
    armed_d     = armed_q;
    ctimer_d    = ctimer_q;
    cap_data_d  = cap_data_q;
    cap_fault_d = cap_fault_q;
    busy_d      = busy_q;
    dav_d       = dav_q;
    err_d       = err_q;
    result_d    = result_q;
    op_cnt_d    = op_cnt_q;
    btimer_d    = btimer_q;
    rejected    = 1'b0;

    if (tick_i) begin
      if (armed_q) begin
        ctimer_d = ctimer_dec;
        if (ctimer_dec == '0) begin
          armed_d = 1'b0;
          if (pending_q) begin
            busy_d = 1'b0;
            if (cap_fault_q[FaultError]) begin
              err_d = 1'b1;
            end else if (cap_fault_q[FaultOnes]) begin
              result_d = AllOnes;
              dav_d    = 1'b1;
            end else begin
              result_d = cap_data_q;
              dav_d    = 1'b1;
            end
            op_cnt_d    = op_cnt_q + 32'd1;
            pending_d   = 1'b0;
            cap_fault_d = '0;
          end
        end
      end
      // Stuck busy is checked after the completion so it wins.
      btimer_d = btimer_inc;
      if (btimer_inc >= BtW'(BUSY_PERIOD)) begin
        btimer_d = '0;
        if (cfg_i.fault_select[FaultStuck]) begin
          busy_d = 1'b1;
        end
      end
    end

    if (go_i) begin
      if (pending_q) begin
        rejected = 1'b1;
      end else begin
        cap_data_d = command_data_i;
        busy_d     = 1'b1;
        dav_d      = 1'b0;
        pending_d  = 1'b1;
        if (fault && cfg_i.fault_select[FaultTimeout]) begin
          armed_d = 1'b0;
        end else begin
          cap_fault_d = fault ? cfg_i.fault_select : 4'd0;
          ctimer_d    = (cfg_i.command_delay == '0) ? 32'd1 : cfg_i.command_delay;
          armed_d     = 1'b1;
        end
      end
    end

    if (evt_i.en_rise) begin
      btimer_d = '0;
    end
    if (evt_i.en_fall) begin
      armed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      armed_q     <= 1'b0;
      ctimer_q    <= '0;
      cap_data_q  <= '0;
      cap_fault_q <= '0;
      busy_q      <= 1'b0;
      dav_q       <= 1'b0;
      err_q       <= 1'b0;
      result_q    <= '0;
      op_cnt_q    <= '0;
      btimer_q    <= '0;
    end else begin
      pending_q   <= pending_d;
      armed_q     <= armed_d;
      ctimer_q    <= ctimer_d;
      cap_data_q  <= cap_data_d;
      cap_fault_q <= cap_fault_d;
      busy_q      <= busy_d;
      dav_q       <= dav_d;
      err_q       <= err_d;
      result_q    <= result_d;
      op_cnt_q    <= op_cnt_d;
      btimer_q    <= btimer_d;
    end
  end

  assign view_o.busy     = busy_d;
  assign view_o.dav      = dav_d;
  assign view_o.err      = err_d;
  assign view_o.result   = result_d;
  assign view_o.op_count = op_cnt_d;
  assign view_o.rejected = rejected;

endmodule

// ===== rtl/core/dcd_outq.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Two-word output buffer so a new word can enter while one waits.
// ----------------------------------------------------------------------------
module dcd_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dcd_pkg::res_item_t  push_data_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dcd_pkg::res_item_t  out_data_o
);
  import dcd_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  res_item_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/dcd_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the result channel of the delayed command device.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input dcd_pkg::res_item_t out_word_i
);
  import dcd_pkg::*;

  logic        out_acc;
  logic        seen_q;
  logic        err_seen_q;
  logic [31:0] last_cnt_q;

  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      err_seen_q <= 1'b0;
      last_cnt_q <= '0;
    end else if (out_acc) begin
      seen_q     <= 1'b1;
      err_seen_q <= err_seen_q || out_word_i.error_flag;
      last_cnt_q <= out_word_i.operation_count;
    end
  end

  // A refused GO can only happen with a command pending, which keeps busy up.
  `ASSERT_RST(a_reject_busy, clk_i, rst_ni, out_valid_i && out_word_i.rejected |-> out_word_i.busy_res, "rejected word without busy")

  // Once reported, the error bit never drops again.
  `ASSERT_RST(a_err_sticky, clk_i, rst_ni, out_valid_i && err_seen_q |-> out_word_i.error_flag, "error flag cleared")

  // At most one completion per word, so the count moves by zero or one.
  `ASSERT_RST(a_count_step, clk_i, rst_ni, out_valid_i && seen_q |-> (out_word_i.operation_count == last_cnt_q) || (out_word_i.operation_count == last_cnt_q + 32'd1), "operation count jumped")

  `ASSERT_ALWAYS(a_out_hold, clk_i, rst_ni && out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i), "stalled result changed")

endmodule

bind delayed_command_device_with_faults dcd_checker u_dcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_word_i  (result_o.payload)
);
